@@ sv/bhab_pkg.sv @@
// Shared types and constants of the bump heap allocator.
package bhab_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REINIT = 2'd2
  } req_t;

  // Result codes carried by status.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LENGTH = 1'd1;

  // Reset values and fixed regions.
  localparam logic [31:0] HEAP_BASE_RST   = 32'h0020_0000;
  localparam logic [31:0] HEAP_LENGTH_RST = 32'h0010_0000;
  localparam logic [31:0] RESV_START      = 32'h0010_0000;
  localparam logic [31:0] RESV_SIZE       = 32'h0002_0000;
  localparam logic [32:0] MAX33           = 33'h1_FFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    scan_clr;
    logic    scan_step;
    logic    take;
    logic    release_slot;
    logic    reinit;
    logic    report;
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       over;
    logic       slot_free;
    logic       scan_last;
    logic       rd_done;
    logic       free_hit;
    logic       cmp_vld;
    logic       cmp_last;
  } stat_t;

endpackage

@@ sv/bhab_if.sv @@
// Request and response channel interfaces of the bump heap allocator.
interface bhab_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] alloc_size;
  logic [31:0] free_addr;

  modport source (output valid, output req_type, output alloc_size, output free_addr,
                  input ready);
  modport sink (input valid, input req_type, input alloc_size, input free_addr,
                output ready);
endinterface

interface bhab_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] granted_addr;
  logic [31:0] free_bytes;
  logic [32:0] used_bytes;

  modport source (output valid, output status, output granted_addr, output free_bytes,
                  output used_bytes, input ready);
  modport sink (input valid, input status, input granted_addr, input free_bytes,
                input used_bytes, output ready);
endinterface

@@ sv/bump_heap_allocator_with_block_table.sv @@
// Top level of the bump heap allocator with its table of block slots.
//
//   channel | direction | handshake     | payload
//   req     | in        | valid / ready | req_type, alloc_size, free_addr
//   rsp     | out       | valid / ready | status, granted_addr, free_bytes, used_bytes
//   cfg     | in        | cfg_we        | cfg_index, cfg_data (no read-back)
//
// One item is in work at a time. Reinitialize, unused codes and an exhausted
// allocate go from dispatch straight to report; an allocate and a free first pass
// through the one-slot-a-cycle scan of the slot table before the report.
// Reset is synchronous and restores the reserved slot, the heap pointer and the registers.
// A stalled result holds in the output register; the next item is still accepted.
module bump_heap_allocator_with_block_table #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  bhab_req_if.sink                        req,
  bhab_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [bhab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bhab_pkg::CFG_DATA_W-1:0] cfg_data
);

  bhab_pkg::cmd_t  cmd;
  bhab_pkg::stat_t stat;

  bhab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bhab_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_req_type   (req.req_type),
    .in_alloc_size (req.alloc_size),
    .in_free_addr  (req.free_addr),
    .cmd           (cmd),
    .stat          (stat),
    .status        (rsp.status),
    .granted_addr  (rsp.granted_addr),
    .free_bytes    (rsp.free_bytes),
    .used_bytes    (rsp.used_bytes)
  );

`ifndef ASSERT_OFF
  // One item at a time: after an accepted item the block is busy.
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while another is in work");

  // A result is only loaded into a free or draining output register.
  a_report_slot : assert property (@(posedge clk) disable iff (rst)
    cmd.report |-> (!rsp.valid || rsp.ready))
    else $error("result overwrote a waiting result");

  // A new result appears only after a report command.
  a_rsp_source : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.report))
    else $error("result valid without a report");

  // A slot is never taken and released in the same cycle.
  a_take_release : assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && cmd.release_slot))
    else $error("take and release together");
`endif

endmodule

@@ sv/bhab_dp.sv @@
// Datapath: configuration, slot table, heap pointer, byte total and result registers.
module bhab_dp #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bhab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bhab_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                     in_req_type,
  input  logic [31:0]                    in_alloc_size,
  input  logic [31:0]                    in_free_addr,
  input  bhab_pkg::cmd_t                 cmd,
  output bhab_pkg::stat_t                stat,
  output logic [1:0]                     status,
  output logic [31:0]                    granted_addr,
  output logic [31:0]                    free_bytes,
  output logic [32:0]                    used_bytes
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SUM_W = 32 + $clog2(SLOT_COUNT);

  logic [31:0]           heap_base;
  logic [31:0]           heap_length;
  logic [1:0]            req_type;
  logic [31:0]           alloc_size;
  logic [31:0]           free_addr;
  logic [32:0]           bump_pointer;
  logic [SUM_W-1:0]      used_sum;
  logic [31:0]           grant;
  logic [SLOT_COUNT-1:0] slot_used;
  logic [SLOT_COUNT-1:0] slot_written;
  logic [31:0]           start_mem [SLOT_COUNT];
  logic [31:0]           size_mem [SLOT_COUNT];
  logic [31:0]           start_q;
  logic [31:0]           size_q;
  logic                  written_q;
  logic [CNT_W-1:0]      rd_cnt;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  cmp_vld;
  logic [31:0]           start_eff;
  logic [31:0]           size_eff;
  logic [32:0]           heap_end;
  logic [33:0]           alloc_end;
  logic [33:0]           bump_round;
  logic [32:0]           distance;
  logic [31:0]           free_calc;

  assign rd_idx = rd_cnt[IDX_W-1:0];

  // Configuration registers; they never move the heap pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= bhab_pkg::HEAP_BASE_RST;
      heap_length <= bhab_pkg::HEAP_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhab_pkg::REG_HEAP_BASE:   heap_base   <= cfg_data;
        bhab_pkg::REG_HEAP_LENGTH: heap_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request item.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type   <= in_req_type;
      alloc_size <= in_alloc_size;
      free_addr  <= in_free_addr;
    end
  end

  // Heap end and bound check, all without wrap.
  assign heap_end   = {1'b0, heap_base} + {1'b0, heap_length};
  assign alloc_end  = {1'b0, bump_pointer} + {2'b00, alloc_size};
  assign bump_round = alloc_end + 34'd3;

  // Scan counter and the compare index, a registered copy of the read index.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.scan_clr) begin
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
      if (cmd.scan_step) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx <= rd_idx;
    end
  end

  // Slot start and size memories with registered reads.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      start_mem[rd_idx] <= bump_pointer[31:0];
    end
    start_q <= start_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      size_mem[rd_idx] <= alloc_size;
    end
    size_q <= size_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    written_q <= slot_written[rd_idx];
  end

  // An entry never written since the last clear reads as its reset value.
  always_comb begin
    if (written_q) begin
      start_eff = start_q;
      size_eff  = size_q;
    end else if (cmp_idx == '0) begin
      start_eff = bhab_pkg::RESV_START;
      size_eff  = bhab_pkg::RESV_SIZE;
    end else begin
      start_eff = '0;
      size_eff  = '0;
    end
  end

  // Slot flags, heap pointer and exact running total of used bytes.
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      slot_used    <= SLOT_COUNT'(1);
      slot_written <= '0;
      used_sum     <= SUM_W'(bhab_pkg::RESV_SIZE);
    end else if (cmd.take) begin
      slot_used[rd_idx]    <= 1'b1;
      slot_written[rd_idx] <= 1'b1;
      used_sum             <= used_sum + SUM_W'(alloc_size);
    end else if (cmd.release_slot) begin
      slot_used[cmp_idx] <= 1'b0;
      used_sum           <= used_sum - SUM_W'(size_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_pointer <= {1'b0, bhab_pkg::HEAP_BASE_RST};
    end else if (cmd.reinit) begin
      bump_pointer <= {1'b0, heap_base};
    end else if (cmd.take) begin
      bump_pointer <= bump_round[33] ? bhab_pkg::MAX33 : {bump_round[32:2], 2'b00};
    end
  end

  // Granted address of the current item.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      grant <= '0;
    end else if (cmd.take) begin
      grant <= bump_pointer[31:0];
    end
  end

  // Free bytes to the heap end, clamped to 32 bits.
  assign distance = heap_end - bump_pointer;
  always_comb begin
    if (bump_pointer >= heap_end) begin
      free_calc = '0;
    end else if (distance[32]) begin
      free_calc = '1;
    end else begin
      free_calc = distance[31:0];
    end
  end

  // Result registers, loaded once the state reflects the item.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      status       <= cmd.status;
      granted_addr <= grant;
      free_bytes   <= free_calc;
      used_bytes   <= (used_sum > SUM_W'(bhab_pkg::MAX33)) ? bhab_pkg::MAX33 : used_sum[32:0];
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.req_type  = req_type;
    stat.over      = alloc_end > {1'b0, heap_end};
    stat.slot_free = !slot_used[rd_idx];
    stat.scan_last = rd_cnt == CNT_W'(SLOT_COUNT - 1);
    stat.rd_done   = rd_cnt == CNT_W'(SLOT_COUNT);
    stat.free_hit  = cmp_vld && slot_used[cmp_idx] && (start_eff == free_addr);
    stat.cmp_vld   = cmp_vld;
    stat.cmp_last  = cmp_idx == IDX_W'(SLOT_COUNT - 1);
  end

endmodule

@@ sv/bhab_ctrl.sv @@
// Controller state machine: sequences one request through dispatch, scan and report.
module bhab_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bhab_pkg::stat_t stat,
  output bhab_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ASCAN,
    S_FSCAN,
    S_REPORT
  } state_t;

  state_t            state;
  state_t            state_next;
  bhab_pkg::status_t status_q;
  bhab_pkg::status_t status_next;
  logic              out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    status_next    = status_q;
    cmd            = '0;
    cmd.status     = status_q;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        status_next  = bhab_pkg::ST_OK;
        state_next   = S_REPORT;
        case (bhab_pkg::req_t'(stat.req_type))
          bhab_pkg::REQ_ALLOC: begin
            if (stat.over) begin
              status_next = bhab_pkg::ST_EXHAUSTED;
            end else begin
              state_next = S_ASCAN;
            end
          end
          bhab_pkg::REQ_FREE:   state_next = S_FSCAN;
          bhab_pkg::REQ_REINIT: cmd.reinit = 1'b1;
          default: ;
        endcase
      end
      S_ASCAN: begin
        if (stat.slot_free) begin
          cmd.take    = 1'b1;
          status_next = bhab_pkg::ST_OK;
          state_next  = S_REPORT;
        end else if (stat.scan_last) begin
          status_next = bhab_pkg::ST_NO_SLOT;
          state_next  = S_REPORT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FSCAN: begin
        if (stat.free_hit) begin
          cmd.release_slot = 1'b1;
          status_next      = bhab_pkg::ST_OK;
          state_next       = S_REPORT;
        end else if (stat.cmp_vld && stat.cmp_last) begin
          status_next = bhab_pkg::ST_NOT_FOUND;
          state_next  = S_REPORT;
        end else begin
          cmd.scan_step = !stat.rd_done;
        end
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          cmd.report     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status_q  <= bhab_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      status_q  <= status_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
